// File: hw/rtl/sctp_chunk_bundling_admission_core_assert.svh
// Assertion macros for the chunk bundling admission block.
// Used by sctp_chunk_bundling_admission_core.sv; empty when SYNTHESIS is defined.
`ifndef SCTP_CHUNK_BUNDLING_ADMISSION_CORE_ASSERT_SVH
`define SCTP_CHUNK_BUNDLING_ADMISSION_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising edge, switched off while reset is asserted.
`define SCBA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define SCBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCBA_ASSERT(lbl, clk, rstn, prop, msg)
`define SCBA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hw/rtl/sctp_cba_pkg.sv
// Package for the chunk bundling admission block: request and status codes,
// reset values and sizes. No dependencies.
`timescale 1ns / 1ps

package sctp_cba_pkg;

  localparam int unsigned DATA_HDR_BYTES = 16;

  localparam int unsigned MTU_W   = 16;
  localparam int unsigned BURST_W = 8;
  localparam int unsigned OVH_W   = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned WIN_W   = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [MTU_W-1:0]   PATH_MTU_RST  = 16'd1500;
  localparam logic [BURST_W-1:0] BURST_LIM_RST = 8'd4;
  localparam logic [OVH_W-1:0]   HDR_OVH_RST   = 8'd32;

  localparam logic [SIZE_W-1:0] SIZE_MAX = 17'h1_FFFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PATH_MTU  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BURST_LIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HDR_OVH   = 2'd2;

  typedef enum logic [1:0] {
    REQ_OFFER = 2'd0,
    REQ_FLUSH = 2'd1,
    REQ_LOAD  = 2'd2,
    REQ_NEW   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PKT_FULL  = 2'd1,
    ST_WIN_FULL  = 2'd2,
    ST_MUST_FRAG = 2'd3
  } status_e;

  typedef struct packed {
    req_type_e         req_type;
    logic [LEN_W-1:0]  chunk_length;
    logic              is_data;
    logic              has_tsn;
    logic              is_cookie_echo;
    logic              fast_rtx;
    logic [WIN_W-1:0]  load_cwnd;
    logic [WIN_W-1:0]  load_flight;
    logic [WIN_W-1:0]  load_rwnd;
    logic [WIN_W-1:0]  load_outstanding;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic              flushed;
    logic [SIZE_W-1:0] flushed_size;
    logic [SIZE_W-1:0] packet_size;
    logic              ip_frag_ok;
    logic              cookie_present;
    logic [WIN_W-1:0]  cwnd_now;
    logic [WIN_W-1:0]  rwnd_now;
  } rsp_t;

endpackage

// File: hw/rtl/sctp_cba_if.sv
// Valid/ready channel interfaces for chunk requests and admission results.
// Depends on sctp_cba_pkg.
`timescale 1ns / 1ps

interface sctp_cba_req_if import sctp_cba_pkg::*; ();
  logic             valid;
  logic             ready;
  req_type_e        req_type;
  logic [LEN_W-1:0] chunk_length;
  logic             is_data;
  logic             has_tsn;
  logic             is_cookie_echo;
  logic             fast_rtx;
  logic [WIN_W-1:0] load_cwnd;
  logic [WIN_W-1:0] load_flight;
  logic [WIN_W-1:0] load_rwnd;
  logic [WIN_W-1:0] load_outstanding;

  modport source (
    output valid, req_type, chunk_length, is_data, has_tsn, is_cookie_echo,
           fast_rtx, load_cwnd, load_flight, load_rwnd, load_outstanding,
    input  ready
  );
  modport sink (
    input  valid, req_type, chunk_length, is_data, has_tsn, is_cookie_echo,
           fast_rtx, load_cwnd, load_flight, load_rwnd, load_outstanding,
    output ready
  );
endinterface

interface sctp_cba_rsp_if import sctp_cba_pkg::*; ();
  logic              valid;
  logic              ready;
  status_e           status;
  logic              flushed;
  logic [SIZE_W-1:0] flushed_size;
  logic [SIZE_W-1:0] packet_size;
  logic              ip_frag_ok;
  logic              cookie_present;
  logic [WIN_W-1:0]  cwnd_now;
  logic [WIN_W-1:0]  rwnd_now;

  modport source (
    output valid, status, flushed, flushed_size, packet_size, ip_frag_ok,
           cookie_present, cwnd_now, rwnd_now,
    input  ready
  );
  modport sink (
    input  valid, status, flushed, flushed_size, packet_size, ip_frag_ok,
           cookie_present, cwnd_now, rwnd_now,
    output ready
  );
endinterface

// File: hw/rtl/sctp_chunk_bundling_admission_core.sv
// SCTP chunk bundling admission: one decision per request.
// A request is captured in the input register, passes the decision logic and
// is registered in the result register.
// Throughput: one request per cycle while rsp_o.ready holds; the packet/window state
// commits as the request moves into the result register, so the next one sees it at once.
// Reset (async, active low): window counters and flags zero, pkt_size 32.
`timescale 1ns / 1ps
`include "sctp_chunk_bundling_admission_core_assert.svh"

module sctp_chunk_bundling_admission_core import sctp_cba_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  sctp_cba_req_if.sink         req_i,
  sctp_cba_rsp_if.source       rsp_o
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [MTU_W-1:0]   mtu_q;
  logic [BURST_W-1:0] burst_q;
  logic [OVH_W-1:0]   ovh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q   <= PATH_MTU_RST;
      burst_q <= BURST_LIM_RST;
      ovh_q   <= HDR_OVH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_PATH_MTU:  mtu_q   <= cfg_data_i[MTU_W-1:0];
        CFG_IDX_BURST_LIM: burst_q <= cfg_data_i[BURST_W-1:0];
        CFG_IDX_HDR_OVH:   ovh_q   <= cfg_data_i[OVH_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: input register (s1) feeding the result register
  // ---------------------------------------------------------------------
  logic s1_valid_q;
  req_t s1_q;
  logic rsp_valid_q;
  rsp_t rsp_q;
  logic s2_load;
  logic in_fire;

  assign s2_load     = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s2_load;
  assign in_fire     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (in_fire)      s1_valid_q <= 1'b1;
      else if (s2_load) s1_valid_q <= 1'b0;
      if (s2_load)          rsp_valid_q <= 1'b1;
      else if (rsp_o.ready) rsp_valid_q <= 1'b0;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.req_type         <= req_i.req_type;
      s1_q.chunk_length     <= req_i.chunk_length;
      s1_q.is_data          <= req_i.is_data;
      s1_q.has_tsn          <= req_i.has_tsn;
      s1_q.is_cookie_echo   <= req_i.is_cookie_echo;
      s1_q.fast_rtx         <= req_i.fast_rtx;
      s1_q.load_cwnd        <= req_i.load_cwnd;
      s1_q.load_flight      <= req_i.load_flight;
      s1_q.load_rwnd        <= req_i.load_rwnd;
      s1_q.load_outstanding <= req_i.load_outstanding;
    end
  end

  // ---------------------------------------------------------------------
  // Packet and window state
  // ---------------------------------------------------------------------
  logic [SIZE_W-1:0] pkt_q, pkt_d;
  logic              hc_q, hc_d;          // packet holds at least one chunk
  logic              cookie_q, cookie_d;
  logic              frag_q, frag_d;
  logic [WIN_W-1:0]  cwnd_q, cwnd_d;
  logic [WIN_W-1:0]  flight_q, flight_d;
  logic [WIN_W-1:0]  rwnd_q, rwnd_d;
  logic [WIN_W-1:0]  outst_q, outst_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q    <= SIZE_W'(HDR_OVH_RST);
      hc_q     <= 1'b0;
      cookie_q <= 1'b0;
      frag_q   <= 1'b0;
      cwnd_q   <= '0;
      flight_q <= '0;
      rwnd_q   <= '0;
      outst_q  <= '0;
    end else if (s2_load) begin
      pkt_q    <= pkt_d;
      hc_q     <= hc_d;
      cookie_q <= cookie_d;
      frag_q   <= frag_d;
      cwnd_q   <= cwnd_d;
      flight_q <= flight_d;
      rwnd_q   <= rwnd_d;
      outst_q  <= outst_d;
    end
  end

  // ---------------------------------------------------------------------
  // Decision datapath
  // ---------------------------------------------------------------------
  logic [SIZE_W-1:0]  rlen_sum;
  logic [SIZE_W-1:0]  rlen;             // length rounded up to a multiple of 4
  logic [LEN_W-1:0]   payload;          // DATA payload bytes
  logic [SIZE_W:0]    cur_sum;
  logic               full_hit;         // does not fit a non-empty packet
  logic               flush_first;      // send the packet, then retry
  logic [SIZE_W-1:0]  base_size;
  logic [SIZE_W:0]    base_sum;
  logic               too_big;
  logic [MTU_W+BURST_W-1:0] burst_bytes;
  logic [WIN_W:0]     burst_sum;
  logic [WIN_W-1:0]   cwnd_cl;
  logic               rwnd_fail;
  logic               cwnd_fail;
  logic [WIN_W:0]     flight_sum;
  logic [WIN_W:0]     outst_sum;

  assign rlen_sum = {1'b0, s1_q.chunk_length} + SIZE_W'(3);
  assign rlen     = {rlen_sum[SIZE_W-1:2], 2'b00};
  assign payload  = (s1_q.chunk_length > LEN_W'(DATA_HDR_BYTES))
                  ? s1_q.chunk_length - LEN_W'(DATA_HDR_BYTES) : '0;

  assign cur_sum     = {1'b0, pkt_q} + {1'b0, rlen};
  assign full_hit    = hc_q && (cur_sum > (SIZE_W+1)'(mtu_q));
  assign flush_first = full_hit && !cookie_q;
  // After a flush the retry runs on an empty packet of header size.
  assign base_size   = flush_first ? SIZE_W'(ovh_q) : pkt_q;
  assign base_sum    = {1'b0, base_size} + {1'b0, rlen};
  assign too_big     = base_sum > (SIZE_W+1)'(mtu_q);

  // Burst clamp: cwnd may not exceed flight + burst limit * MTU
  assign burst_bytes = (MTU_W+BURST_W)'(burst_q) * (MTU_W+BURST_W)'(mtu_q);
  assign burst_sum   = {1'b0, flight_q} + (WIN_W+1)'(burst_bytes);
  assign cwnd_cl     = (burst_sum < {1'b0, cwnd_q}) ? burst_sum[WIN_W-1:0] : cwnd_q;

  assign rwnd_fail  = (WIN_W'(payload) > rwnd_q) && (outst_q != '0);
  assign cwnd_fail  = !s1_q.fast_rtx && (flight_q >= cwnd_cl);
  assign flight_sum = {1'b0, flight_q} + (WIN_W+1)'(payload);
  assign outst_sum  = {1'b0, outst_q} + (WIN_W+1)'(payload);

  status_e           status;
  logic              flushed;
  logic [SIZE_W-1:0] flushed_size;

  always_comb begin
    logic admit;
    admit        = 1'b0;
    pkt_d        = pkt_q;
    hc_d         = hc_q;
    cookie_d     = cookie_q;
    frag_d       = frag_q;
    cwnd_d       = cwnd_q;
    flight_d     = flight_q;
    rwnd_d       = rwnd_q;
    outst_d      = outst_q;
    status       = ST_OK;
    flushed      = 1'b0;
    flushed_size = '0;

    case (s1_q.req_type)
      REQ_OFFER: begin
        if (full_hit && cookie_q) begin
          // cookie echo bundled: the packet is held, chunk refused
          status = ST_PKT_FULL;
        end else begin
          if (flush_first) begin
            flushed      = 1'b1;
            flushed_size = pkt_q;
            pkt_d        = SIZE_W'(ovh_q);
            hc_d         = 1'b0;
          end
          if (too_big && s1_q.is_data && !s1_q.has_tsn) begin
            status = ST_MUST_FRAG;
          end else begin
            if (too_big) frag_d = 1'b1;   // lone oversized chunk
            admit = 1'b1;
            if (s1_q.is_data) begin
              if (rwnd_fail) begin
                status = ST_WIN_FULL;
                admit  = 1'b0;
              end else begin
                cwnd_d = cwnd_cl;
                if (cwnd_fail) begin
                  status = ST_WIN_FULL;
                  admit  = 1'b0;
                end else begin
                  flight_d = flight_sum[WIN_W] ? '1 : flight_sum[WIN_W-1:0];
                  outst_d  = outst_sum[WIN_W] ? '1 : outst_sum[WIN_W-1:0];
                  rwnd_d   = (WIN_W'(payload) < rwnd_q) ? rwnd_q - WIN_W'(payload) : '0;
                end
              end
            end else if (s1_q.is_cookie_echo) begin
              cookie_d = 1'b1;
            end
            if (admit) begin
              pkt_d = base_sum[SIZE_W] ? SIZE_MAX : base_sum[SIZE_W-1:0];
              hc_d  = 1'b1;
            end
          end
        end
      end
      REQ_FLUSH: begin
        flushed      = hc_q;
        flushed_size = hc_q ? pkt_q : '0;
        pkt_d        = SIZE_W'(ovh_q);
        hc_d         = 1'b0;
      end
      REQ_LOAD: begin
        cwnd_d   = s1_q.load_cwnd;
        flight_d = s1_q.load_flight;
        rwnd_d   = s1_q.load_rwnd;
        outst_d  = s1_q.load_outstanding;
      end
      REQ_NEW: begin
        cookie_d = 1'b0;
        frag_d   = 1'b0;
        if (!hc_q) pkt_d = SIZE_W'(ovh_q);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      rsp_q.status         <= status;
      rsp_q.flushed        <= flushed;
      rsp_q.flushed_size   <= flushed_size;
      rsp_q.packet_size    <= pkt_d;
      rsp_q.ip_frag_ok     <= frag_d;
      rsp_q.cookie_present <= cookie_d;
      rsp_q.cwnd_now       <= cwnd_d;
      rsp_q.rwnd_now       <= rwnd_d;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_q.status;
  assign rsp_o.flushed        = rsp_q.flushed;
  assign rsp_o.flushed_size   = rsp_q.flushed_size;
  assign rsp_o.packet_size    = rsp_q.packet_size;
  assign rsp_o.ip_frag_ok     = rsp_q.ip_frag_ok;
  assign rsp_o.cookie_present = rsp_q.cookie_present;
  assign rsp_o.cwnd_now       = rsp_q.cwnd_now;
  assign rsp_o.rwnd_now       = rsp_q.rwnd_now;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `SCBA_ASSERT(a_noflush_nosize, clk_i, rst_ni,
               rsp_valid_q && !rsp_q.flushed |-> rsp_q.flushed_size == '0,
               "flushed_size set without a flush")
  `SCBA_ASSERT(a_full_holds_pkt, clk_i, rst_ni,
               rsp_valid_q && rsp_q.status == ST_PKT_FULL |->
                 !rsp_q.flushed && rsp_q.cookie_present,
               "packet full reported although the packet could be sent")
  `SCBA_ASSERT(a_s1_moves, clk_i, rst_ni,
               s2_load |=> rsp_valid_q && !$stable(rsp_valid_q) || rsp_valid_q,
               "decision lost on its way to the result register")
  `SCBA_ASSERT_ALWAYS(a_stall_only_full, clk_i, !req_i.ready |-> s1_valid_q,
                      "request refused with an empty input register")

endmodule

// File: tb/sctp_chunk_bundling_admission_core_tb.sv
// Self-checking bench for the SCTP chunk bundling admission core.
// Predictor or typed-in row checks each result: directed table, then random requests.
// Depends on sctp_cba_pkg, sctp_cba_if and sctp_chunk_bundling_admission_core.
`timescale 1ns / 1ps

module sctp_chunk_bundling_admission_core_tb;
  import sctp_cba_pkg::*;

  localparam int unsigned N_PHASES    = 6;
  localparam int unsigned N_RAND      = 305;  // random requests per phase
  localparam int unsigned HOLD_CYCLES = 200;  // long receiver hold-off
  localparam int unsigned WDOG_LIMIT  = 3000; // cycles with no handshake at all
  localparam int unsigned MAX_SHOWN   = 40;   // mismatch lines printed

  // Register index 3 is not decoded; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  // Settings per phase; phase 0 keeps the reset values.
  localparam logic [MTU_W-1:0]   PH_MTU   [N_PHASES] = '{16'd1500, 16'd65535, 16'd0,
                                                         16'd576, 16'd9000, 16'd1500};
  localparam logic [BURST_W-1:0] PH_BURST [N_PHASES] = '{8'd4, 8'd255, 8'd0, 8'd1, 8'd2,
                                                         8'd4};
  localparam logic [OVH_W-1:0]   PH_OVH   [N_PHASES] = '{8'd32, 8'd255, 8'd0, 8'd20, 8'd48,
                                                         8'd32};

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } stim_row_t;

  typedef struct {
    bit   typed;
    rsp_t want;
  } typed_exp_t;

  logic clk_i;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  sctp_cba_req_if req_if ();
  sctp_cba_rsp_if rsp_if ();

  sctp_chunk_bundling_admission_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // 12 ns clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Idle rates in percent; written by the stimulus process only.
  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;
  int unsigned hold_reqs = 0;  // bumped to ask the receiver for a long hold-off

  // Predictor copy of the block: configuration and packet/window state.
  logic [MTU_W-1:0]   mtu_q;
  logic [BURST_W-1:0] burst_q;
  logic [OVH_W-1:0]   ovh_q;
  logic [SIZE_W-1:0]  pkt_sz;
  logic               cookie_q;
  logic               frag_q;
  logic               has_chunks_q;
  logic [WIN_W-1:0]   cwnd_q;
  logic [WIN_W-1:0]   flight_q;
  logic [WIN_W-1:0]   rwnd_q;
  logic [WIN_W-1:0]   outst_q;

  typed_exp_t typed_q[$];   // per request, in order: typed-in expectation or none
  rsp_t       result_q[$];  // admission results still owed by the block
  int unsigned err_cnt = 0;
  int unsigned n_res = 0;
  int unsigned stall_cycles = 0;

  task automatic report_mismatch(string what, logic [WIN_W-1:0] want, logic [WIN_W-1:0] got);
    err_cnt++;
    if (err_cnt <= MAX_SHOWN) begin
      $display("[%0t] result %0d: %s, expected 0x%0h, got 0x%0h", $time, n_res, what, want,
               got);
    end
  endtask

  function automatic logic [WIN_W-1:0] sat_add(logic [WIN_W-1:0] a, logic [WIN_W-1:0] b);
    logic [WIN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WIN_W] ? '1 : s[WIN_W-1:0];
  endfunction

  // Sends the packet if it holds chunks; returns the size sent or zero.
  function automatic logic [SIZE_W-1:0] flush_pkt();
    logic [SIZE_W-1:0] sent;
    sent = has_chunks_q ? pkt_sz : '0;
    pkt_sz = {9'd0, ovh_q};
    has_chunks_q = 1'b0;
    return sent;
  endfunction

  // One attempt to add the chunk to the current packet.
  function automatic status_e try_fit(logic [SIZE_W-1:0] rlen, logic [WIN_W-1:0] pay,
                                      req_t r);
    logic [63:0] burst_sum;
    logic [63:0] grown;
    if (64'(pkt_sz) + 64'(rlen) > 64'(mtu_q)) begin
      if (has_chunks_q) return ST_PKT_FULL;
      if (r.is_data && !r.has_tsn) return ST_MUST_FRAG;
      // lone oversized chunk: IP fragmentation allowed, sticks even if refused below
      frag_q = 1'b1;
    end
    if (r.is_data) begin
      if (pay > rwnd_q && outst_q != '0) return ST_WIN_FULL;
      burst_sum = 64'(flight_q) + 64'(burst_q) * 64'(mtu_q);
      if (burst_sum < 64'(cwnd_q)) cwnd_q = burst_sum[WIN_W-1:0];
      if (!r.fast_rtx && flight_q >= cwnd_q) return ST_WIN_FULL;
      flight_q = sat_add(flight_q, pay);
      outst_q  = sat_add(outst_q, pay);
      rwnd_q   = (pay < rwnd_q) ? rwnd_q - pay : '0;
    end else if (r.is_cookie_echo) begin
      cookie_q = 1'b1;
    end
    grown = 64'(pkt_sz) + 64'(rlen);
    pkt_sz = (grown > 64'(SIZE_MAX)) ? SIZE_MAX : grown[SIZE_W-1:0];
    has_chunks_q = 1'b1;
    return ST_OK;
  endfunction

  function automatic rsp_t predict_admission(req_t r);
    rsp_t o;
    logic [SIZE_W-1:0] rlen;
    logic [WIN_W-1:0]  pay;
    o = '0;
    case (r.req_type)
      REQ_OFFER: begin
        rlen = ({1'b0, r.chunk_length} + 17'd3) & ~17'd3;
        pay = (r.chunk_length > DATA_HDR_BYTES) ? 32'(r.chunk_length) - DATA_HDR_BYTES : '0;
        o.status = try_fit(rlen, pay, r);
        // no room: send the packet and retry, unless a cookie echo pins it
        if (o.status == ST_PKT_FULL && !cookie_q) begin
          o.flushed = has_chunks_q;
          o.flushed_size = flush_pkt();
          o.status = try_fit(rlen, pay, r);
        end
      end
      REQ_FLUSH: begin
        o.flushed = has_chunks_q;
        o.flushed_size = flush_pkt();
      end
      REQ_LOAD: begin
        cwnd_q   = r.load_cwnd;
        flight_q = r.load_flight;
        rwnd_q   = r.load_rwnd;
        outst_q  = r.load_outstanding;
      end
      default: begin
        cookie_q = 1'b0;
        frag_q = 1'b0;
        if (!has_chunks_q) pkt_sz = {9'd0, ovh_q};
      end
    endcase
    o.packet_size    = pkt_sz;
    o.ip_frag_ok     = frag_q;
    o.cookie_present = cookie_q;
    o.cwnd_now       = cwnd_q;
    o.rwnd_now       = rwnd_q;
    return o;
  endfunction

  task automatic check_result(rsp_t want);
    if (rsp_if.status !== want.status)
      report_mismatch("status", WIN_W'(want.status), WIN_W'(rsp_if.status));
    if (rsp_if.flushed !== want.flushed)
      report_mismatch("flushed", WIN_W'(want.flushed), WIN_W'(rsp_if.flushed));
    if (rsp_if.flushed_size !== want.flushed_size)
      report_mismatch("flushed_size", WIN_W'(want.flushed_size), WIN_W'(rsp_if.flushed_size));
    if (rsp_if.packet_size !== want.packet_size)
      report_mismatch("packet_size", WIN_W'(want.packet_size), WIN_W'(rsp_if.packet_size));
    if (rsp_if.ip_frag_ok !== want.ip_frag_ok)
      report_mismatch("ip_frag_ok", WIN_W'(want.ip_frag_ok), WIN_W'(rsp_if.ip_frag_ok));
    if (rsp_if.cookie_present !== want.cookie_present)
      report_mismatch("cookie_present", WIN_W'(want.cookie_present),
                      WIN_W'(rsp_if.cookie_present));
    if (rsp_if.cwnd_now !== want.cwnd_now)
      report_mismatch("cwnd_now", want.cwnd_now, rsp_if.cwnd_now);
    if (rsp_if.rwnd_now !== want.rwnd_now)
      report_mismatch("rwnd_now", want.rwnd_now, rsp_if.rwnd_now);
  endtask

  // Scoreboard and watchdog. Inputs change by NBA, so everything read here is the
  // value that stood at the edge. Results are retired before new requests enter.
  always @(posedge clk_i) begin : scoreboard
    req_t       seen;
    typed_exp_t row;
    rsp_t       pred;
    bit         moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (rsp_if.valid && rsp_if.ready) begin
        moved = 1'b1;
        n_res++;
        if (result_q.size() == 0) report_mismatch("result with nothing expected", '0, '0);
        else check_result(result_q.pop_front());
      end
      if (req_if.valid && req_if.ready) begin
        moved = 1'b1;
        seen.req_type         = req_if.req_type;
        seen.chunk_length     = req_if.chunk_length;
        seen.is_data          = req_if.is_data;
        seen.has_tsn          = req_if.has_tsn;
        seen.is_cookie_echo   = req_if.is_cookie_echo;
        seen.fast_rtx         = req_if.fast_rtx;
        seen.load_cwnd        = req_if.load_cwnd;
        seen.load_flight      = req_if.load_flight;
        seen.load_rwnd        = req_if.load_rwnd;
        seen.load_outstanding = req_if.load_outstanding;
        pred = predict_admission(seen);
        row = typed_q.pop_front();
        result_q.push_back(row.typed ? row.want : pred);
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, plus a long hold-off on request so that
  // the block backs up and stalls its request input.
  initial begin : rx_side
    int unsigned holds_done;
    holds_done = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  function automatic req_t mk_offer(logic [LEN_W-1:0] len, logic data, logic tsn,
                                    logic cookie, logic fast);
    req_t r;
    r = '0;
    r.req_type = REQ_OFFER;
    r.chunk_length = len;
    r.is_data = data;
    r.has_tsn = tsn;
    r.is_cookie_echo = cookie;
    r.fast_rtx = fast;
    return r;
  endfunction

  function automatic req_t mk_ctl(req_type_e kind);
    req_t r;
    r = '0;
    r.req_type = kind;
    return r;
  endfunction

  function automatic req_t mk_load(logic [WIN_W-1:0] cw, logic [WIN_W-1:0] fl,
                                   logic [WIN_W-1:0] rw, logic [WIN_W-1:0] os);
    req_t r;
    r = '0;
    r.req_type = REQ_LOAD;
    r.load_cwnd = cw;
    r.load_flight = fl;
    r.load_rwnd = rw;
    r.load_outstanding = os;
    return r;
  endfunction

  // Typed-in result with nothing flushed and both flags clear.
  function automatic rsp_t mk_rsp(status_e st, logic [SIZE_W-1:0] pkt,
                                  logic [WIN_W-1:0] cw, logic [WIN_W-1:0] rw);
    rsp_t o;
    o = '0;
    o.status = st;
    o.packet_size = pkt;
    o.cwnd_now = cw;
    o.rwnd_now = rw;
    return o;
  endfunction

  // Random request: mostly offers, most small or up to just past the MTU, with window
  // loads that keep DATA admissions going, and a share of raw noise.
  function automatic req_t rand_req();
    req_t r;
    int unsigned pick;
    int unsigned cw;
    pick = $urandom_range(0, 99);
    if (pick < 70)      r.req_type = REQ_OFFER;
    else if (pick < 78) r.req_type = REQ_FLUSH;
    else if (pick < 88) r.req_type = REQ_LOAD;
    else                r.req_type = REQ_NEW;
    pick = $urandom_range(0, 99);
    if (pick < 55)      r.chunk_length = 16'($urandom_range(0, 300));
    else if (pick < 80) r.chunk_length = 16'($urandom_range(0, 32'(mtu_q) + 64));
    else if (pick < 93) r.chunk_length = 16'($urandom());
    else if (pick < 97) r.chunk_length = 16'($urandom_range(0, 4));
    else                r.chunk_length = 16'hFFFC | 16'($urandom_range(0, 3));
    r.is_data         = ($urandom_range(0, 99) < 60);
    r.has_tsn         = 1'($urandom_range(0, 1));
    r.is_cookie_echo  = ($urandom_range(0, 99) < 15);
    r.fast_rtx        = ($urandom_range(0, 99) < 20);
    if ($urandom_range(0, 3) == 0) begin
      r.load_cwnd        = $urandom();
      r.load_flight      = $urandom();
      r.load_rwnd        = $urandom();
      r.load_outstanding = $urandom();
    end else begin
      cw = $urandom_range(0, 200000);
      r.load_cwnd        = cw;
      r.load_flight      = $urandom_range(0, cw);
      r.load_rwnd        = $urandom_range(0, 100000);
      r.load_outstanding = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(0, 50000));
    end
    return r;
  endfunction

  // Offers one request and returns at the edge where it is taken.
  task automatic send_req(req_t r, bit typed, rsp_t want);
    while ($urandom_range(0, 99) < snd_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    typed_q.push_back('{typed, want});
    req_if.req_type         <= r.req_type;
    req_if.chunk_length     <= r.chunk_length;
    req_if.is_data          <= r.is_data;
    req_if.has_tsn          <= r.has_tsn;
    req_if.is_cookie_echo   <= r.is_cookie_echo;
    req_if.fast_rtx         <= r.fast_rtx;
    req_if.load_cwnd        <= r.load_cwnd;
    req_if.load_flight      <= r.load_flight;
    req_if.load_rwnd        <= r.load_rwnd;
    req_if.load_outstanding <= r.load_outstanding;
    req_if.valid            <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Stops offering and waits until every result is in; the core holds nothing
  // once its last result has left, and spare edges cover the pipeline.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Register write; the predictor follows at the same edge. Upper data bits
  // beyond a register's width are junk on purpose.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_IDX_PATH_MTU:  mtu_q = data;
      CFG_IDX_BURST_LIM: burst_q = data[BURST_W-1:0];
      CFG_IDX_HDR_OVH:   ovh_q = data[OVH_W-1:0];
      default: ;
    endcase
  endtask

  initial begin : stimulus
    stim_row_t dir_tbl[$];
    rsp_t      none;
    none = '0;

    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_IDX_PATH_MTU;
    cfg_data_i <= '0;
    req_if.valid            <= 1'b0;
    req_if.req_type         <= REQ_OFFER;
    req_if.chunk_length     <= '0;
    req_if.is_data          <= 1'b0;
    req_if.has_tsn          <= 1'b0;
    req_if.is_cookie_echo   <= 1'b0;
    req_if.fast_rtx         <= 1'b0;
    req_if.load_cwnd        <= '0;
    req_if.load_flight      <= '0;
    req_if.load_rwnd        <= '0;
    req_if.load_outstanding <= '0;
    rst_ni <= 1'b0;

    mtu_q = PATH_MTU_RST;
    burst_q = BURST_LIM_RST;
    ovh_q = HDR_OVH_RST;
    pkt_sz = {9'd0, HDR_OVH_RST};
    cookie_q = 1'b0;
    frag_q = 1'b0;
    has_chunks_q = 1'b0;
    cwnd_q = '0;
    flight_q = '0;
    rwnd_q = '0;
    outst_q = '0;

    // Directed table, run on the reset settings. Rows typed in where the answer
    // is plain from the reset state; the rest go through the predictor.
    // new packet and flush on an empty packet straight after reset
    dir_tbl.push_back('{mk_ctl(REQ_NEW), 1'b1, mk_rsp(ST_OK, 17'd32, '0, '0)});
    dir_tbl.push_back('{mk_ctl(REQ_FLUSH), 1'b1, mk_rsp(ST_OK, 17'd32, '0, '0)});
    // largest DATA chunk without TSN, empty packet: must fragment
    dir_tbl.push_back('{mk_offer(16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0), 1'b1,
                        mk_rsp(ST_MUST_FRAG, 17'd32, '0, '0)});
    // zero cwnd refuses DATA; fast retransmit ignores it
    dir_tbl.push_back('{mk_offer(16'd100, 1'b1, 1'b0, 1'b0, 1'b0), 1'b1,
                        mk_rsp(ST_WIN_FULL, 17'd32, '0, '0)});
    dir_tbl.push_back('{mk_offer(16'd100, 1'b1, 1'b0, 1'b0, 1'b1), 1'b1,
                        mk_rsp(ST_OK, 17'd132, '0, '0)});
    dir_tbl.push_back('{mk_load(32'd100000, 32'd0, 32'd50000, 32'd0), 1'b1,
                        mk_rsp(ST_OK, 17'd132, 32'd100000, 32'd50000)});
    // burst clamp of cwnd, odd length rounding, cookie echo pinning the packet
    dir_tbl.push_back('{mk_offer(16'd101, 1'b1, 1'b0, 1'b0, 1'b0), 1'b0, none});
    dir_tbl.push_back('{mk_offer(16'd3, 1'b0, 1'b0, 1'b1, 1'b0), 1'b0, none});
    dir_tbl.push_back('{mk_offer(16'd1400, 1'b1, 1'b0, 1'b0, 1'b0), 1'b0, none});
    dir_tbl.push_back('{mk_ctl(REQ_NEW), 1'b0, none});
    // no room and no cookie: packet sent, chunk retried on the empty one
    dir_tbl.push_back('{mk_offer(16'd1400, 1'b1, 1'b0, 1'b0, 1'b0), 1'b0, none});
    dir_tbl.push_back('{mk_ctl(REQ_FLUSH), 1'b0, none});
    // oversized DATA with TSN: fragmentation flag set, then refused by rwnd
    dir_tbl.push_back('{mk_offer(16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0), 1'b0, none});
    dir_tbl.push_back('{mk_offer(16'hFFFD, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, none});
    dir_tbl.push_back('{mk_offer(16'd4, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, none});
    dir_tbl.push_back('{mk_ctl(REQ_NEW), 1'b0, none});
    dir_tbl.push_back('{mk_offer(16'd0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, none});
    // counters at the top: saturation on add, flight >= cwnd
    dir_tbl.push_back('{mk_load('1, '1, '1, '1), 1'b0, none});
    dir_tbl.push_back('{mk_offer(16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b1), 1'b0, none});
    dir_tbl.push_back('{mk_offer(16'd20, 1'b1, 1'b1, 1'b0, 1'b0), 1'b0, none});
    // rwnd probe rule, then rwnd running down to zero; DATA beats cookie echo
    dir_tbl.push_back('{mk_load(32'h8000_0000, 32'd1000, 32'd10, 32'd5), 1'b0, none});
    dir_tbl.push_back('{mk_offer(16'd200, 1'b1, 1'b0, 1'b0, 1'b0), 1'b0, none});
    dir_tbl.push_back('{mk_load(32'd50000, 32'd1000, 32'd10, 32'd0), 1'b0, none});
    dir_tbl.push_back('{mk_offer(16'd200, 1'b1, 1'b0, 1'b1, 1'b0), 1'b0, none});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < N_PHASES; p++) begin
      // receiver slow first, then sender slow, then both flat out
      snd_idle = (p < 2) ? 36 : (p < 4) ? 85 : 0;
      rcv_idle = (p < 2) ? 85 : (p < 4) ? 36 : 0;
      if (p > 0) begin
        wait_idle();
        cfg_write(CFG_IDX_PATH_MTU, PH_MTU[p]);
        cfg_write(CFG_IDX_BURST_LIM, {8'($urandom()), PH_BURST[p]});
        cfg_write(CFG_IDX_HDR_OVH, {8'($urandom()), PH_OVH[p]});
        if (p == N_PHASES - 1) cfg_write(CFG_IDX_SPARE, 16'($urandom()));
        cfg_we_i <= 1'b0;
        @(posedge clk_i);
      end
      if (p == 0) begin
        foreach (dir_tbl[i]) send_req(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].want);
      end
      if (p == 1) hold_reqs++;
      repeat (N_RAND) send_req(rand_req(), 1'b0, none);
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/sctp_cba_pkg.sv
hw/rtl/sctp_cba_if.sv
hw/rtl/sctp_chunk_bundling_admission_core.sv
tb/sctp_chunk_bundling_admission_core_tb.sv
